### sv/itaf_pkg.sv
// itaf_pkg: shared constants and types for the integer-to-ASCII formatter.
// No dependencies; compile first.
`default_nettype none

package itaf_pkg;

	localparam int unsigned VALUE_BITS      = 32;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	localparam logic [1:0] CMD_UDEC  = 2'd0;
	localparam logic [1:0] CMD_FIXED = 2'd1;
	localparam logic [1:0] CMD_HEX   = 2'd2;

	localparam logic [3:0] DEC_FRAC_MAX   = 4'd9;
	localparam logic [3:0] HEX_DIGITS_MAX = 4'd8;
	localparam logic [3:0] MAX_RESULTS    = 4'd12;
	localparam logic [3:0] DEC_RADIX      = 4'd10;
	localparam logic [3:0] DABBLE_LIMIT   = 4'd5;
	localparam logic [3:0] DABBLE_ADJUST  = 4'd3;

	localparam logic [6:0] ASC_ZERO    = 7'h30;
	localparam logic [6:0] ASC_UPPER_A = 7'h41;
	localparam logic [6:0] ASC_MINUS   = 7'h2D;
	localparam logic [6:0] ASC_DOT     = 7'h2E;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_DEC,
		ST_HEX
	} state_t;

endpackage

`default_nettype wire

### sv/itaf_in_if.sv
// itaf_in_if: request channel of the formatter (command, value, digit count).
// Depends on itaf_pkg.
`default_nettype none

interface itaf_in_if import itaf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            cmd;
	logic [VALUE_BITS-1:0] value;
	logic [3:0]            count;

	modport source (output valid, output cmd, output value, output count, input ready);
	modport sink   (input valid, input cmd, input value, input count, output ready);
endinterface

`default_nettype wire

### sv/itaf_out_if.sv
// itaf_out_if: character channel of the formatter (ASCII code, last flag).
// Depends on itaf_pkg.
`default_nettype none

interface itaf_out_if import itaf_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

### sv/int_to_ascii_formatter.sv
// int_to_ascii_formatter: bit-serial binary-to-BCD conversion and character emitter.
// Depends on itaf_pkg, itaf_in_if, itaf_out_if.
//
//   channel  dir  word                          handshake
//   req      in   cmd[1:0] value[31:0] count[3:0]  valid/ready
//   rsp      out  char_code[6:0] last            valid/ready
//
// Decimal modes: accept, then VALUE_WIDTH double-dabble shifts, then the characters are
// emitted and leading zeros are suppressed (at most ND-1 of them, ND = 10 BCD digits at
// the default width). Hex mode: accept, then one character per nibble. One word is in
// flight; req.ready is high in idle, also while the last character waits in the output
// register. A stalled rsp holds the emitter.
`default_nettype none

module int_to_ascii_formatter import itaf_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	itaf_in_if.sink     req,
	itaf_out_if.source  rsp
);

	localparam int unsigned ND_RAW    = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int unsigned ND        = (ND_RAW > 10) ? ND_RAW : 10;
	localparam int unsigned BCD_W     = ND * 4;
	localparam int unsigned POS_W     = $clog2(ND);
	localparam int unsigned CMP_W     = (POS_W > 4) ? POS_W : 4;
	localparam int unsigned BIT_CNT_W = $clog2(VALUE_WIDTH + 1);

	state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_next;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [POS_W-1:0]       pos_q;
	logic [3:0]             cnt_q;
	logic [2:0]             idx_q;
	logic [3:0]             n_q;
	logic [31:0]            hex_q;
	logic                   sign_pend_q;
	logic                   dot_done_q;
	logic                   seen_q;

	logic                   ovalid_q;
	logic [6:0]             ochar_q;
	logic                   olast_q;

	logic [VALUE_WIDTH-1:0] val_w;
	logic                   val_neg;
	logic [VALUE_WIDTH-1:0] val_mag;
	logic [3:0]             cnt_load;

	logic [3:0]             top_digit;
	logic [3:0]             hex_nib;
	logic [CMP_W-1:0]       pos_ext;
	logic [CMP_W-1:0]       cnt_ext;
	logic                   out_free;
	logic                   trunc;
	logic                   dot_now;
	logic                   skip_now;

	logic                   accept;
	logic                   emit;
	logic [6:0]             emit_char;
	logic                   emit_last;
	logic                   dec_shift;
	logic                   sign_take;
	logic                   dot_take;

	assign val_w    = VALUE_WIDTH'(req.value);
	assign val_neg  = (req.cmd == CMD_FIXED) && val_w[VALUE_WIDTH-1];
	assign val_mag  = val_neg ? (~val_w + VALUE_WIDTH'(1)) : val_w;

	always_comb begin
		case (req.cmd)
			CMD_FIXED: cnt_load = (req.count > DEC_FRAC_MAX) ? DEC_FRAC_MAX : req.count;
			CMD_HEX:   cnt_load = (req.count > HEX_DIGITS_MAX) ? HEX_DIGITS_MAX : req.count;
			default:   cnt_load = 4'd0;
		endcase
	end

	always_comb begin
		logic [3:0] d;
		logic [BCD_W-1:0] adj;
		adj = '0;
		for (int i = 0; i < int'(ND); i++) begin
			d = bcd_q[i*4 +: 4];
			adj[i*4 +: 4] = (d >= DABBLE_LIMIT) ? d + DABBLE_ADJUST : d;
		end
		bcd_next = {adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign hex_nib   = hex_q[{idx_q, 2'b00} +: 4];
	assign pos_ext   = CMP_W'(pos_q);
	assign cnt_ext   = CMP_W'(cnt_q);
	assign out_free  = !ovalid_q || rsp.ready;
	assign trunc     = (n_q == MAX_RESULTS - 4'd1);
	assign dot_now   = (cnt_q != 4'd0) && !dot_done_q && (pos_ext == cnt_ext - CMP_W'(1));
	assign skip_now  = !seen_q && (top_digit == 4'd0) && (pos_ext > cnt_ext);
	assign accept    = req.valid && req.ready;

	// outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		emit      = 1'b0;
		emit_char = ASC_ZERO;
		emit_last = 1'b0;
		dec_shift = 1'b0;
		sign_take = 1'b0;
		dot_take  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_DEC: begin
				if (sign_pend_q) begin
					emit      = out_free;
					emit_char = ASC_MINUS;
					emit_last = trunc;
					sign_take = out_free;
				end else if (dot_now) begin
					emit      = out_free;
					emit_char = ASC_DOT;
					emit_last = trunc;
					dot_take  = out_free;
				end else if (skip_now) begin
					dec_shift = 1'b1;
				end else begin
					emit      = out_free;
					emit_char = ASC_ZERO + 7'(top_digit);
					emit_last = trunc || (pos_q == '0);
					dec_shift = out_free;
				end
			end
			ST_HEX: begin
				emit      = out_free;
				emit_char = (hex_nib < DEC_RADIX) ? ASC_ZERO + 7'(hex_nib)
				                                  : ASC_UPPER_A + 7'(hex_nib - DEC_RADIX);
				emit_last = trunc || (idx_q == 3'd0);
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.cmd)
						CMD_UDEC, CMD_FIXED: state_d = ST_CONV;
						CMD_HEX:             state_d = (cnt_load != 4'd0) ? ST_HEX : ST_IDLE;
						default:             state_d = ST_IDLE;
					endcase
				end
			end
			ST_CONV: begin
				if (bit_cnt_q == BIT_CNT_W'(1)) begin
					state_d = ST_DEC;
				end
			end
			ST_DEC, ST_HEX: begin
				if (emit && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ochar_q <= emit_char;
			olast_q <= emit_last;
			n_q     <= n_q + 4'd1;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mag_q       <= val_mag;
					bcd_q       <= '0;
					bit_cnt_q   <= BIT_CNT_W'(VALUE_WIDTH);
					pos_q       <= POS_W'(ND - 1);
					cnt_q       <= cnt_load;
					idx_q       <= 3'(cnt_load - 4'd1);
					n_q         <= 4'd0;
					hex_q       <= 32'(val_w);
					sign_pend_q <= val_neg;
					dot_done_q  <= 1'b0;
					seen_q      <= 1'b0;
				end
			end
			ST_CONV: begin
				bcd_q     <= bcd_next;
				mag_q     <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
			end
			ST_DEC: begin
				if (sign_take) begin
					sign_pend_q <= 1'b0;
				end
				if (dot_take) begin
					dot_done_q <= 1'b1;
				end
				if (dec_shift) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
					pos_q <= pos_q - POS_W'(1);
					if (!skip_now) begin
						seen_q <= 1'b1;
					end
				end
			end
			ST_HEX: begin
				if (emit) begin
					idx_q <= idx_q - 3'd1;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid     = ovalid_q;
	assign rsp.char_code = ochar_q;
	assign rsp.last      = olast_q;

	a_last_ends_word: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == ST_IDLE))
		else $error("formatter kept running after the last character");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DEC) || (state_q == ST_HEX)) |-> (n_q < MAX_RESULTS))
		else $error("character count exceeded its limit");

	a_fraction_after_int: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DEC) && (pos_ext < cnt_ext)) |-> (seen_q && !sign_pend_q))
		else $error("fraction digit reached before integer part");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !rsp.ready) |-> !emit)
		else $error("character emitted over a pending word");

endmodule

`default_nettype wire
